// ----- hdl/multicart_outer_bank_mapper_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multicart outer bank mapper
// Concurrent check macros; they compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MULTICART_OUTER_BANK_MAPPER_MACROS_SVH
`define MULTICART_OUTER_BANK_MAPPER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MOBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define MOBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MOBM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MOBM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/mobm_pkg.sv -----
// ----------------------------------------------------------------------------
// Multicart outer bank mapper package
// Request and result types, request codes and register bit positions.
// ----------------------------------------------------------------------------
package mobm_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_CPU_WRITE = 2'd0,
    REQ_PRG_XLATE = 2'd1,
    REQ_CHR_XLATE = 2'd2,
    REQ_RESERVED  = 2'd3
  } req_kind_t;

  // mirroring codes
  typedef enum logic [1:0] {
    MIRROR_VERTICAL    = 2'd0,
    MIRROR_HORIZONTAL  = 2'd1,
    MIRROR_FOUR_SCREEN = 2'd2
  } mirror_t;

  // outer register bit positions
  localparam int unsigned LockBit       = 6;  // register 3
  localparam int unsigned FourScreenBit = 6;  // register 2
  localparam int unsigned ChrRomBit     = 5;  // register 2

  // outer register reset values
  localparam logic [7:0] Reg0Reset = 8'h00;
  localparam logic [7:0] Reg1Reset = 8'h00;
  localparam logic [7:0] Reg2Reset = 8'h0F;
  localparam logic [7:0] Reg3Reset = 8'h00;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] access_address;
    logic [7:0]  data_value;
    logic        wram_writable;
    logic        inner_mirroring;
  } req_t;

  typedef struct packed {
    logic [11:0] bank_number;
    logic        bank_is_chr_ram;
    logic [1:0]  mirroring_mode;
    logic        forward_to_inner;
    logic        outer_reg_written;
  } res_t;

endpackage

// ----- hdl/mobm_ifs.sv -----
// ----------------------------------------------------------------------------
// Multicart outer bank mapper channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------

// request channel
interface mobm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] access_address;
  logic [7:0]  data_value;
  logic        wram_writable;
  logic        inner_mirroring;

  modport source (
    output valid, req_type, access_address, data_value, wram_writable, inner_mirroring,
    input  ready
  );
  modport sink (
    input  valid, req_type, access_address, data_value, wram_writable, inner_mirroring,
    output ready
  );
endinterface

// result channel
interface mobm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] bank_number;
  logic        bank_is_chr_ram;
  logic [1:0]  mirroring_mode;
  logic        forward_to_inner;
  logic        outer_reg_written;

  modport source (
    output valid, bank_number, bank_is_chr_ram, mirroring_mode, forward_to_inner,
    output outer_reg_written,
    input  ready
  );
  modport sink (
    input  valid, bank_number, bank_is_chr_ram, mirroring_mode, forward_to_inner,
    input  outer_reg_written,
    output ready
  );
endinterface

// configuration write channel
interface mobm_cfg_if;
  logic valid;
  logic ready;
  logic chr_ram_present;

  modport source (
    output valid, chr_ram_present,
    input  ready
  );
  modport sink (
    input  valid, chr_ram_present,
    output ready
  );
endinterface

// ----- hdl/mobm_core.sv -----
// ----------------------------------------------------------------------------
// Multicart outer bank mapper core
// Outer registers, round-robin write pointer and bank translation logic.
// ----------------------------------------------------------------------------
`include "multicart_outer_bank_mapper_macros.svh"

module mobm_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  mobm_pkg::req_t req,
  input  logic           chr_ram_present,
  output mobm_pkg::res_t res
);

  logic [7:0] regs_r [4];
  logic [1:0] wp_r;

  logic       in_window;
  logic       high_write;
  logic       do_write;
  logic [7:0] reg2_after;
  logic [9:0] prg_base;
  logic [5:0] prg_mask;
  logic [9:0] prg_bank;
  logic [11:0] chr_base;
  logic [3:0] chr_shift;
  logic [7:0] chr_mask;
  logic [11:0] chr_bank;
  logic       chr_use_ram;

  // cpu write decode
  assign in_window  = (req.access_address[15:13] == 3'b011);
  assign high_write = req.access_address[15];
  assign do_write   = (mobm_pkg::req_kind_t'(req.req_type) == mobm_pkg::REQ_CPU_WRITE)
                      && in_window && !regs_r[3][mobm_pkg::LockBit] && req.wram_writable;

  // register 2 as seen after this request
  assign reg2_after = (do_write && (wp_r == 2'd2)) ? req.data_value : regs_r[2];

  // prg merge
  assign prg_base = {regs_r[2][7:6], regs_r[1]};
  assign prg_mask = ~regs_r[3][5:0];
  assign prg_bank = (prg_base & ~{4'b0000, prg_mask}) | {4'b0000, req.data_value[5:0] & prg_mask};

  // chr merge
  assign chr_base    = {regs_r[2][7:4], regs_r[0]};
  assign chr_shift   = ~regs_r[2][3:0];
  assign chr_mask    = 8'hFF >> chr_shift;
  assign chr_bank    = (chr_base & ~{4'h0, chr_mask}) | {4'h0, req.data_value & chr_mask};
  assign chr_use_ram = !regs_r[2][mobm_pkg::ChrRomBit] && chr_ram_present;

  // result decode
  always_comb begin
    res = '0;
    if (reg2_after[mobm_pkg::FourScreenBit]) begin
      res.mirroring_mode = mobm_pkg::MIRROR_FOUR_SCREEN;
    end else if (req.inner_mirroring) begin
      res.mirroring_mode = mobm_pkg::MIRROR_HORIZONTAL;
    end else begin
      res.mirroring_mode = mobm_pkg::MIRROR_VERTICAL;
    end
    unique case (mobm_pkg::req_kind_t'(req.req_type))
      mobm_pkg::REQ_CPU_WRITE: begin
        res.outer_reg_written = do_write;
        res.forward_to_inner  = high_write;
      end
      mobm_pkg::REQ_PRG_XLATE: begin
        res.bank_number = {2'b00, prg_bank};
      end
      mobm_pkg::REQ_CHR_XLATE: begin
        if (chr_use_ram) begin
          res.bank_is_chr_ram = 1'b1;
          res.bank_number     = {9'd0, req.access_address[12:10]};
        end else begin
          res.bank_number = chr_bank;
        end
      end
      default: begin
      end
    endcase
  end

  // outer registers and pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[0] <= mobm_pkg::Reg0Reset;
      regs_r[1] <= mobm_pkg::Reg1Reset;
      regs_r[2] <= mobm_pkg::Reg2Reset;
      regs_r[3] <= mobm_pkg::Reg3Reset;
      wp_r      <= 2'd0;
    end else if (accept && do_write) begin
      regs_r[wp_r] <= req.data_value;
      wp_r         <= wp_r + 2'd1;
    end
  end

  // checks
  `MOBM_ASSERT_NXT(a_ptr_step, clk, rst_n, accept && res.outer_reg_written, wp_r == $past(wp_r) + 2'd1)
  `MOBM_ASSERT_NXT(a_ptr_hold, clk, rst_n, !(accept && res.outer_reg_written), $stable(wp_r))
  `MOBM_ASSERT_IMP(a_lock_blocks, clk, rst_n, regs_r[3][mobm_pkg::LockBit], !res.outer_reg_written)

endmodule

// ----- hdl/mobm_skid.sv -----
// ----------------------------------------------------------------------------
// Multicart outer bank mapper result buffer
// Two-entry output stage: result register plus skid register.
// ----------------------------------------------------------------------------
`include "multicart_outer_bank_mapper_macros.svh"

module mobm_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mobm_pkg::res_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mobm_pkg::res_t out_data
);

  mobm_pkg::res_t main_r, main_nxt;
  mobm_pkg::res_t skid_r, skid_nxt;
  logic           main_v_r, main_v_nxt;
  logic           skid_v_r, skid_v_nxt;
  logic           push;
  logic           pop;

  assign in_ready  = !skid_v_r;
  assign push      = in_valid && in_ready;
  assign pop       = main_v_r && out_ready;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // next buffer state
  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!main_v_r) begin
      main_nxt   = in_data;
      main_v_nxt = push;
    end else if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = in_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = in_data;
      skid_v_nxt = 1'b1;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // checks
  `MOBM_ASSERT_IMP(a_skid_behind_main, clk, rst_n, skid_v_r, main_v_r)
  `MOBM_ASSERT_NXT(a_skid_holds, clk, rst_n, skid_v_r && !out_ready, skid_v_r && main_v_r)
  `MOBM_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_v_r && out_ready, main_v_r && !skid_v_r)

endmodule

// ----- hdl/multicart_outer_bank_mapper.sv -----
// ----------------------------------------------------------------------------
// Multicart outer bank mapper
// Outer bank registers and PRG/CHR bank merge for an MMC3-based multicart.
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_ch     in    req_type, access_address, data_value, wram_writable,
//                 inner_mirroring
// out_ch    out   bank_number, bank_is_chr_ram, mirroring_mode,
//                 forward_to_inner, outer_reg_written
// cfg_ch    in    chr_ram_present (always ready)
//
// one request per cycle while in_ch is ready; its result is valid the cycle
// after the transfer in the result register behind the merge logic, unless
// out_ch stalls; a two-entry output buffer takes one more transfer during an
// out stall; in_ch drops ready while the second entry is full
// synchronous active-low reset: outer regs 0,0,0x0F,0, pointer 0, buffer empty
// ----------------------------------------------------------------------------
module multicart_outer_bank_mapper (
  input  logic       clk,
  input  logic       rst_n,
  mobm_in_if.sink    in_ch,
  mobm_out_if.source out_ch,
  mobm_cfg_if.sink   cfg_ch
);

  logic           chr_ram_present_r;
  logic           in_ready;
  logic           accept;
  mobm_pkg::req_t req;
  mobm_pkg::res_t res;
  mobm_pkg::res_t out_data;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_ram_present_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      chr_ram_present_r <= cfg_ch.chr_ram_present;
    end
  end

  // request transfer
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign req.req_type        = in_ch.req_type;
  assign req.access_address  = in_ch.access_address;
  assign req.data_value      = in_ch.data_value;
  assign req.wram_writable   = in_ch.wram_writable;
  assign req.inner_mirroring = in_ch.inner_mirroring;

  mobm_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .req             (req),
    .chr_ram_present (chr_ram_present_r),
    .res             (res)
  );

  mobm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_data   (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // result fields
  assign out_ch.bank_number       = out_data.bank_number;
  assign out_ch.bank_is_chr_ram   = out_data.bank_is_chr_ram;
  assign out_ch.mirroring_mode    = out_data.mirroring_mode;
  assign out_ch.forward_to_inner  = out_data.forward_to_inner;
  assign out_ch.outer_reg_written = out_data.outer_reg_written;

endmodule
